@@ rtl/mtep_pkg.sv @@
// Package for the MIDI track event parser.
// Phase, kind and error codes, status byte constants and the result record.
// No dependencies.
`default_nettype none

package mtep_pkg;

  localparam int unsigned MAX_VLQ_BYTES_DEF = 4;

  localparam logic [30:0] MAX_TRACK_RST = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_LEN,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VOICE,
    KIND_MODE,
    KIND_META,
    KIND_SYSEX
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_ID,
    ERR_BAD_LEN,
    ERR_NO_RUNNING,
    ERR_BAD_DATA,
    ERR_BAD_STATUS,
    ERR_OVERRUN
  } err_t;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROG      = 4'hC;
  localparam logic [3:0] HI_PRESS     = 4'hD;
  localparam logic [7:0] MODE_MASK    = 8'h78;

  localparam logic [7:0] TRACK_ID [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

  typedef struct packed {
    kind_t       event_kind;
    logic [27:0] delta_time;
    logic [7:0]  status_value;
    logic [7:0]  meta_kind;
    logic [30:0] event_bytes;
    err_t        error_code;
    logic        chunk_end;
  } rec_t;

endpackage

`default_nettype wire

@@ rtl/mtep_core.sv @@
// Parser state machine: header check, delta time, status and data decode.
// One byte per step; produces at most one record per byte.
// Depends on mtep_pkg.
`default_nettype none

module mtep_core #(
  parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     data_byte,
  input  wire logic           chunk_start,
  input  wire logic [30:0]    max_track_bytes,
  output logic                res_valid,
  output mtep_pkg::rec_t      rec
);

  localparam int unsigned VW = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;
  localparam logic [VW-1:0] VLQ_LAST = VW'(MAX_VLQ_BYTES - 1);

  mtep_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [2:0]    hdr_cnt_r, hdr_cnt_nxt, cur_hdr;
  logic [31:0]   len_r, len_nxt, cur_len;
  logic [30:0]   cons_r, cons_nxt, cur_cons;
  logic [7:0]    run_r, run_nxt, cur_run;
  logic [27:0]   delta_r, delta_nxt, cur_delta;
  logic [VW-1:0] vlq_r, vlq_nxt, cur_vlq;
  logic [27:0]   skip_r, skip_nxt, cur_skip;
  logic [7:0]    status_r, status_nxt, cur_status;
  logic [7:0]    meta_r, meta_nxt, cur_meta;
  logic [30:0]   ev_start_r, ev_start_nxt, cur_ev_start;
  logic          err_r, err_nxt, cur_err;
  logic          id_ok_r, id_ok_nxt, cur_id_ok;
  logic          mode_r, mode_nxt, cur_mode;

  logic [30:0]   cons_inc;
  logic [31:0]   total;
  logic          at_end;
  logic          vlq_end;
  logic [27:0]   acc_delta;
  logic [27:0]   acc_skip;
  logic [2:0]    hdr_inc;
  logic          emit;
  mtep_pkg::kind_t emit_kind;
  mtep_pkg::kind_t sys_kind;
  mtep_pkg::err_t  err_code;
  logic          chk_over;
  logic          take_d1;
  logic          empty_chunk;
  logic          start_evt;

  always_comb begin
    if (chunk_start) begin
      cur_phase    = mtep_pkg::PH_HEADER;
      cur_hdr      = '0;
      cur_len      = '0;
      cur_cons     = '0;
      cur_run      = '0;
      cur_delta    = '0;
      cur_vlq      = '0;
      cur_skip     = '0;
      cur_status   = '0;
      cur_meta     = '0;
      cur_ev_start = '0;
      cur_err      = 1'b0;
      cur_id_ok    = 1'b1;
      cur_mode     = 1'b0;
    end else begin
      cur_phase    = phase_r;
      cur_hdr      = hdr_cnt_r;
      cur_len      = len_r;
      cur_cons     = cons_r;
      cur_run      = run_r;
      cur_delta    = delta_r;
      cur_vlq      = vlq_r;
      cur_skip     = skip_r;
      cur_status   = status_r;
      cur_meta     = meta_r;
      cur_ev_start = ev_start_r;
      cur_err      = err_r;
      cur_id_ok    = id_ok_r;
      cur_mode     = mode_r;
    end

    phase_nxt    = cur_phase;
    hdr_cnt_nxt  = cur_hdr;
    len_nxt      = cur_len;
    cons_nxt     = cur_cons;
    run_nxt      = cur_run;
    delta_nxt    = cur_delta;
    vlq_nxt      = cur_vlq;
    skip_nxt     = cur_skip;
    status_nxt   = cur_status;
    meta_nxt     = cur_meta;
    ev_start_nxt = cur_ev_start;
    err_nxt      = cur_err;
    id_ok_nxt    = cur_id_ok;
    mode_nxt     = cur_mode;

    cons_inc  = cur_cons + 31'd1;
    total     = {1'b0, cur_len[30:0]} + 32'd8;
    at_end    = ({1'b0, cons_inc} == total);
    vlq_end   = !data_byte[7] || (cur_vlq == VLQ_LAST);
    acc_delta = {cur_delta[20:0], data_byte[6:0]};
    acc_skip  = {cur_skip[20:0], data_byte[6:0]};
    hdr_inc   = cur_hdr + 3'd1;
    sys_kind  = (cur_status == mtep_pkg::ST_META) ? mtep_pkg::KIND_META
                                                  : mtep_pkg::KIND_SYSEX;

    emit        = 1'b0;
    emit_kind   = mtep_pkg::KIND_VOICE;
    err_code    = mtep_pkg::ERR_NONE;
    chk_over    = 1'b0;
    take_d1     = 1'b0;
    empty_chunk = 1'b0;
    start_evt   = 1'b0;
    res_valid   = 1'b0;
    rec         = '0;

    if (!cur_err) begin
      if (cur_phase == mtep_pkg::PH_DONE) begin
        err_code = mtep_pkg::ERR_OVERRUN;
      end else begin
        cons_nxt = cons_inc;
        unique case (cur_phase)
          mtep_pkg::PH_HEADER: begin
            if (!cur_hdr[2]) begin
              if (data_byte != mtep_pkg::TRACK_ID[cur_hdr[1:0]]) id_ok_nxt = 1'b0;
            end else begin
              len_nxt = {cur_len[23:0], data_byte};
            end
            hdr_cnt_nxt = hdr_inc;
            if (hdr_inc == 3'd0) begin
              if (!id_ok_nxt) begin
                err_code = mtep_pkg::ERR_BAD_ID;
              end else if (len_nxt[31] || (max_track_bytes < 31'd8) ||
                           (({1'b0, len_nxt} + 33'd8) > {2'b00, max_track_bytes})) begin
                err_code = mtep_pkg::ERR_BAD_LEN;
              end else if (len_nxt == 32'd0) begin
                empty_chunk = 1'b1;
                phase_nxt   = mtep_pkg::PH_DONE;
              end else begin
                start_evt = 1'b1;
              end
            end
          end
          mtep_pkg::PH_DELTA: begin
            chk_over  = 1'b1;
            delta_nxt = acc_delta;
            if (vlq_end) begin
              phase_nxt = mtep_pkg::PH_STATUS;
              vlq_nxt   = '0;
            end else begin
              vlq_nxt = cur_vlq + 1'b1;
            end
          end
          mtep_pkg::PH_STATUS: begin
            chk_over = 1'b1;
            if (data_byte == mtep_pkg::ST_META) begin
              status_nxt = data_byte;
              run_nxt    = '0;
              phase_nxt  = mtep_pkg::PH_META_TYPE;
            end else if ((data_byte == mtep_pkg::ST_SYSEX) ||
                         (data_byte == mtep_pkg::ST_SYSEX_ESC)) begin
              status_nxt = data_byte;
              run_nxt    = '0;
              skip_nxt   = '0;
              vlq_nxt    = '0;
              phase_nxt  = mtep_pkg::PH_LEN;
            end else if (data_byte[7]) begin
              if (data_byte[7:4] == mtep_pkg::HI_SYSTEM) begin
                err_code = mtep_pkg::ERR_BAD_STATUS;
              end else begin
                status_nxt = data_byte;
                run_nxt    = data_byte;
                phase_nxt  = mtep_pkg::PH_DATA1;
              end
            end else if (!cur_run[7]) begin
              err_code = mtep_pkg::ERR_NO_RUNNING;
            end else begin
              status_nxt = cur_run;
              take_d1    = 1'b1;
            end
          end
          mtep_pkg::PH_DATA1: begin
            chk_over = 1'b1;
            take_d1  = 1'b1;
          end
          mtep_pkg::PH_DATA2: begin
            if (data_byte[7]) begin
              err_code = mtep_pkg::ERR_BAD_DATA;
            end else begin
              emit      = 1'b1;
              emit_kind = cur_mode ? mtep_pkg::KIND_MODE : mtep_pkg::KIND_VOICE;
            end
          end
          mtep_pkg::PH_META_TYPE: begin
            chk_over  = 1'b1;
            meta_nxt  = data_byte;
            skip_nxt  = '0;
            vlq_nxt   = '0;
            phase_nxt = mtep_pkg::PH_LEN;
          end
          mtep_pkg::PH_LEN: begin
            chk_over = 1'b1;
            skip_nxt = acc_skip;
            if (vlq_end) begin
              vlq_nxt = '0;
              if (acc_skip == 28'd0) begin
                emit      = 1'b1;
                emit_kind = sys_kind;
              end else begin
                phase_nxt = mtep_pkg::PH_SKIP;
              end
            end else begin
              vlq_nxt = cur_vlq + 1'b1;
            end
          end
          mtep_pkg::PH_SKIP: begin
            chk_over = 1'b1;
            skip_nxt = cur_skip - 28'd1;
            if (cur_skip == 28'd1) begin
              emit      = 1'b1;
              emit_kind = sys_kind;
            end
          end
          default: begin
            err_code = mtep_pkg::ERR_OVERRUN;
          end
        endcase

        if (take_d1) begin
          if (data_byte[7]) begin
            err_code = mtep_pkg::ERR_BAD_DATA;
          end else begin
            mode_nxt = (status_nxt[7:4] == mtep_pkg::HI_CTRL) &&
                       ((data_byte & mtep_pkg::MODE_MASK) == mtep_pkg::MODE_MASK);
            if ((status_nxt[7:4] == mtep_pkg::HI_PROG) ||
                (status_nxt[7:4] == mtep_pkg::HI_PRESS)) begin
              emit      = 1'b1;
              emit_kind = mtep_pkg::KIND_VOICE;
            end else begin
              phase_nxt = mtep_pkg::PH_DATA2;
            end
          end
        end

        // last chunk byte landed inside an unfinished event
        if (chk_over && at_end && !emit && (err_code == mtep_pkg::ERR_NONE)) begin
          err_code = mtep_pkg::ERR_OVERRUN;
        end
      end
    end

    if (err_code != mtep_pkg::ERR_NONE) begin
      res_valid      = 1'b1;
      rec.error_code = err_code;
      err_nxt        = 1'b1;
    end else if (emit) begin
      res_valid        = 1'b1;
      rec.event_kind   = emit_kind;
      rec.delta_time   = delta_nxt;
      rec.status_value = status_nxt;
      rec.meta_kind    = meta_nxt;
      rec.event_bytes  = cons_inc - cur_ev_start;
      rec.chunk_end    = at_end;
      if (at_end) begin
        phase_nxt = mtep_pkg::PH_DONE;
      end else begin
        start_evt = 1'b1;
      end
    end else if (empty_chunk) begin
      res_valid     = 1'b1;
      rec.chunk_end = 1'b1;
    end

    if (start_evt) begin
      phase_nxt    = mtep_pkg::PH_DELTA;
      delta_nxt    = '0;
      vlq_nxt      = '0;
      skip_nxt     = '0;
      meta_nxt     = '0;
      mode_nxt     = 1'b0;
      ev_start_nxt = cons_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mtep_pkg::PH_HEADER;
      hdr_cnt_r  <= '0;
      len_r      <= '0;
      cons_r     <= '0;
      run_r      <= '0;
      delta_r    <= '0;
      vlq_r      <= '0;
      skip_r     <= '0;
      status_r   <= '0;
      meta_r     <= '0;
      ev_start_r <= '0;
      err_r      <= 1'b0;
      id_ok_r    <= 1'b1;
      mode_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      len_r      <= len_nxt;
      cons_r     <= cons_nxt;
      run_r      <= run_nxt;
      delta_r    <= delta_nxt;
      vlq_r      <= vlq_nxt;
      skip_r     <= skip_nxt;
      status_r   <= status_nxt;
      meta_r     <= meta_nxt;
      ev_start_r <= ev_start_nxt;
      err_r      <= err_nxt;
      id_ok_r    <= id_ok_nxt;
      mode_r     <= mode_nxt;
    end
  end

  a_err_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && (rec.error_code != mtep_pkg::ERR_NONE)) |=> err_r)
    else $error("error record did not latch the error state");

  a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (step && err_r && !chunk_start) |-> !res_valid)
    else $error("record produced while error latched");

  a_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && rec.chunk_end) |=> (phase_r == mtep_pkg::PH_DONE))
    else $error("chunk end without done phase");

  a_event_size: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (rec.error_code == mtep_pkg::ERR_NONE) && (rec.status_value != 8'd0))
    |-> (rec.event_bytes >= 31'd2))
    else $error("event shorter than delta plus one byte");

endmodule

`default_nettype wire

@@ rtl/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: input register, parser core,
// two-entry output buffer and the max_track_bytes register.
// Depends on mtep_pkg and mtep_core.
//
//  channel | dir | tdata                      | tuser                  | tlast
//  in_     | in  | data_byte[7:0]             | chunk_start            | -
//  out_    | out | see port comment           | event_kind, error_code | chunk_end
//  cfg_    | in  | max_track_bytes[30:0]      | -                      | -
//
// One byte per cycle sustained while the output buffer is not full; a record shows on
// out_tvalid once its byte has passed the input register, then the output register.
// Reset clears all parser state, both buffers and sets max_track_bytes to its max.
// The output side holds two records; in_tready falls only when both are full,
// and depends on registers only.
`default_nettype none

module midi_track_event_parser #(
  parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] chunk_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [27:0] delta_time, [35:28] status_value,
                                       // [43:36] meta_kind, [74:44] event_bytes
  output logic [4:0]       out_tuser,  // [1:0] event_kind, [4:2] error_code
  output logic             out_tlast,  // chunk_end
  input  wire logic        cfg_wr_en,
  input  wire logic [30:0] cfg_wr_data
);

  logic           s1_valid_r;
  logic [7:0]     s1_data_r;
  logic           s1_start_r;
  logic [30:0]    max_bytes_r;
  logic           step;
  logic           res_valid;
  mtep_pkg::rec_t res;
  mtep_pkg::rec_t out_r;
  mtep_pkg::rec_t skid_r;
  logic           out_valid_r;
  logic           skid_valid_r;
  logic           push;
  logic           pop;

  assign step      = s1_valid_r && !skid_valid_r;
  assign in_tready = !s1_valid_r || !skid_valid_r;
  assign push      = step && res_valid;
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= mtep_pkg::MAX_TRACK_RST;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  mtep_core #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (s1_data_r),
    .chunk_start    (s1_start_r),
    .max_track_bytes(max_bytes_r),
    .res_valid      (res_valid),
    .rec            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_r.event_bytes, out_r.meta_kind,
                       out_r.status_value, out_r.delta_time};
  assign out_tuser  = {out_r.error_code, out_r.event_kind};
  assign out_tlast  = out_r.chunk_end;

endmodule

`default_nettype wire
